// ===== sv/ils_pkg.sv =====
// Shared operation codes, status codes and cell command type for the indexed list store.
package ils_pkg;

   localparam logic [2:0] OP_APPEND = 3'd0;
   localparam logic [2:0] OP_DROP   = 3'd1;
   localparam logic [2:0] OP_CLEAR  = 3'd2;
   localparam logic [2:0] OP_INSERT = 3'd3;
   localparam logic [2:0] OP_ERASE  = 3'd4;
   localparam logic [2:0] OP_READ   = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic append;
      logic insert;
      logic erase;
   } ils_cmd_type;

endpackage

// ===== sv/indexed_list_store.sv =====
// Indexed list store: top level with the row of cells, fill count and result register.
// The result strobe rises in the cycle after an item is accepted.
// Throughput: one item per cycle; busy stays low, every cell shifts in the same cycle.
// The read word is an OR of one-hot cell selects, registered into the result.
// Reset (synchronous, active high) clears the fill count and the result strobe only.
// The receiver cannot stall: rsp_strobe is high for a single cycle per result.
module indexed_list_store #(
   parameter int DEPTH     = 32,
   parameter int WORD_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_op,
   input  logic [5:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_read_word,
   output logic [5:0]         rsp_count,
   output logic [1:0]         rsp_status
);
   import ils_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   logic                 accept;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic [CMP_W-1:0]     pos_ext;
   logic [CMP_W-1:0]     cnt_ext;
   logic [WORD_BITS-1:0] wr_word;
   logic [WORD_BITS-1:0] rd_bus;
   logic [WORD_BITS-1:0] rd_sel;
   logic [1:0]           status;
   ils_cmd_type          cmd;
   ils_cmd_type          cmd_gated;

   logic [WORD_BITS-1:0] cell_word [DEPTH];
   logic [WORD_BITS-1:0] cell_rd   [DEPTH];

   logic                 rsp_strobe_ff;
   logic [31:0]          rsp_read_word_ff;
   logic [5:0]           rsp_count_ff;
   logic [1:0]           rsp_status_ff;

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign pos_ext = CMP_W'(req_position);
   assign cnt_ext = CMP_W'(count_ff);
   assign wr_word = WORD_BITS'($unsigned(req_value));

   always_comb begin
      rd_bus = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_bus = rd_bus | cell_rd[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      status   = ST_OK;
      cmd      = '0;
      rd_sel   = '0;
      unique case (req_op)
         OP_APPEND: begin
            if (count_ff == FULL_COUNT) begin
               status = ST_FULL;
            end else begin
               cmd.append = 1'b1;
               count_in   = count_ff + 1'b1;
            end
         end
         OP_DROP: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         OP_INSERT: begin
            if (count_ff == FULL_COUNT) begin
               status = ST_FULL;
            end else if (pos_ext > cnt_ext) begin
               status = ST_RANGE;
            end else begin
               cmd.insert = 1'b1;
               count_in   = count_ff + 1'b1;
            end
         end
         OP_ERASE: begin
            if (pos_ext >= cnt_ext) begin
               status = ST_RANGE;
            end else begin
               cmd.erase = 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end
         OP_READ: begin
            if (pos_ext >= cnt_ext) begin
               status = ST_RANGE;
            end else begin
               rd_sel = rd_bus;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   assign cmd_gated = accept ? cmd : '0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [WORD_BITS-1:0] left_word;
      logic [WORD_BITS-1:0] right_word;

      if (g == 0) begin : g_first
         assign left_word = wr_word;
      end else begin : g_mid_l
         assign left_word = cell_word[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign right_word = cell_word[g];
      end else begin : g_mid_r
         assign right_word = cell_word[g+1];
      end

      ils_cell #(
         .INDEX     (g),
         .WORD_BITS (WORD_BITS),
         .CMP_W     (CMP_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd_gated),
         .pos        (pos_ext),
         .count      (cnt_ext),
         .wr_word    (wr_word),
         .left_word  (left_word),
         .right_word (right_word),
         .word_out   (cell_word[g]),
         .rd_word    (cell_rd[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_word_ff <= 32'(rd_sel);
         rsp_count_ff     <= 6'(count_in);
         rsp_status_ff    <= status;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_read_word = rsp_read_word_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_status    = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("fill count above depth");

   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == ($past(accept) && !$past(reset)))
      else $error("result strobe without accepted item");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_FULL) |-> rsp_count == 6'(DEPTH))
      else $error("full status with short list");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_EMPTY) |-> rsp_count == 6'd0)
      else $error("empty status with entries present");

endmodule

// ===== sv/ils_cell.sv =====
// One storage cell of the list: holds one entry and shifts with its neighbours.
module ils_cell #(
   parameter int INDEX     = 0,
   parameter int WORD_BITS = 32,
   parameter int CMP_W     = 6
) (
   input  logic                 clock,
   input  ils_pkg::ils_cmd_type cmd,
   input  logic [CMP_W-1:0]     pos,
   input  logic [CMP_W-1:0]     count,
   input  logic [WORD_BITS-1:0] wr_word,
   input  logic [WORD_BITS-1:0] left_word,
   input  logic [WORD_BITS-1:0] right_word,
   output logic [WORD_BITS-1:0] word_out,
   output logic [WORD_BITS-1:0] rd_word
);
   import ils_pkg::*;

   localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (cmd.append && (count == IDX)) begin
         word_in = wr_word;
      end
      if (cmd.insert) begin
         if (pos == IDX) begin
            word_in = wr_word;
         end else if (IDX > pos) begin
            word_in = left_word;
         end
      end
      if (cmd.erase && (IDX >= pos)) begin
         word_in = right_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;
   assign rd_word  = (pos == IDX) ? word_ff : '0;

endmodule

// ===== dv/tb.sv =====
// Testbench for indexed_list_store: directed table, then random list traffic checked by a predictor.
module tb;
   import ils_pkg::*;

   localparam int LIST_DEPTH   = 32;
   localparam int RANDOM_ITEMS = 1900;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int QUIET_TAIL   = 300;

   localparam logic [2:0] OP_UNUSED_LO = 3'd6;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic signed [31:0] read_word;
      logic [5:0]         count;
      logic [1:0]         status;
   } list_result_type;

   typedef struct {
      logic [2:0]         op;
      logic [5:0]         pos;
      logic signed [31:0] val;
      int                 reps;
      bit                 typed;
      list_result_type    want;
   } list_req_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_op = '0;
   logic [5:0]         req_position = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_strobe;
   logic signed [31:0] rsp_read_word;
   logic [5:0]         rsp_count;
   logic [1:0]         rsp_status;

   logic signed [31:0] shadow_list [LIST_DEPTH];
   logic [5:0]         shadow_count;
   list_result_type    awaited_results [$];

   int error_count   = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int peak_count    = 0;
   int cycle_count   = 0;
   int status_seen [4] = '{0, 0, 0, 0};

   indexed_list_store #(
      .DEPTH(LIST_DEPTH),
      .WORD_BITS(32)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_read_word(rsp_read_word),
      .rsp_count(rsp_count),
      .rsp_status(rsp_status)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic list_req_type row(logic [2:0] op, logic [5:0] pos,
                                        logic signed [31:0] val,
                                        int reps, bit typed, logic signed [31:0] rd,
                                        logic [5:0] cnt, logic [1:0] st);
      list_req_type r;
      r.op    = op;
      r.pos   = pos;
      r.val   = val;
      r.reps  = reps;
      r.typed = typed;
      r.want  = '{read_word: rd, count: cnt, status: st};
      return r;
   endfunction

   function automatic list_result_type apply_list_op(logic [2:0] op, logic [5:0] pos,
                                                     logic signed [31:0] val);
      list_result_type r;
      int j;
      r = '{read_word: '0, count: '0, status: ST_OK};
      case (op)
         OP_APPEND: begin
            if (shadow_count >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_list[shadow_count] = val;
               shadow_count++;
            end
         end
         OP_DROP: begin
            if (shadow_count == 0) r.status = ST_EMPTY;
            else shadow_count--;
         end
         OP_CLEAR: begin
            shadow_count = '0;
         end
         OP_INSERT: begin
            if (shadow_count >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else if (pos > shadow_count) begin
               r.status = ST_RANGE;
            end else begin
               for (j = shadow_count; j > pos; j--) shadow_list[j] = shadow_list[j - 1];
               shadow_list[pos] = val;
               shadow_count++;
            end
         end
         OP_ERASE: begin
            if (pos >= shadow_count) begin
               r.status = ST_RANGE;
            end else begin
               for (j = pos; j + 1 < shadow_count; j++) shadow_list[j] = shadow_list[j + 1];
               shadow_count--;
            end
         end
         OP_READ: begin
            if (pos >= shadow_count) r.status = ST_RANGE;
            else r.read_word = shadow_list[pos];
         end
         default: begin
         end
      endcase
      r.count = shadow_count;
      return r;
   endfunction

   task automatic log_mismatch(input string msg);
      error_count++;
      if (error_count <= 10) $display("mismatch: %s", msg);
   endtask

   task automatic send_item(input logic [2:0] op, input logic [5:0] pos,
                            input logic signed [31:0] val, input bit typed,
                            input list_result_type want);
      list_result_type predicted;
      start        <= 1'b1;
      req_op       <= op;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = apply_list_op(op, pos, val);
      awaited_results.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      start        <= 1'b0;
      req_op       <= 3'($urandom);
      req_position <= 6'($urandom);
      req_value    <= $urandom;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_strobe) begin
         results_seen++;
         status_seen[rsp_status]++;
         if (rsp_count > peak_count) peak_count = rsp_count;
         if (awaited_results.size() == 0) begin
            log_mismatch($sformatf("unexpected result word %h count %0d status %0d",
                                   rsp_read_word, rsp_count, rsp_status));
         end else begin
            want = awaited_results.pop_front();
            if (rsp_read_word !== want.read_word)
               log_mismatch($sformatf("read_word expected %h got %h",
                                      want.read_word, rsp_read_word));
            if (rsp_count !== want.count)
               log_mismatch($sformatf("count expected %0d got %0d", want.count, rsp_count));
            if (rsp_status !== want.status)
               log_mismatch($sformatf("status expected %0d got %0d", want.status, rsp_status));
         end
      end
   end

   initial begin
      list_req_type       directed_rows [$];
      logic [2:0]         op;
      logic [5:0]         pos;
      logic signed [31:0] val;
      bit                 grow;
      bit                 gaps_on;
      int                 phase_left;
      int                 roll;
      int                 i;
      int                 k;

      shadow_count = '0;
      foreach (shadow_list[j]) shadow_list[j] = '0;

      directed_rows.push_back(row(OP_DROP,   6'd0,  32'sd0, 1, 1, 32'sd0, 6'd0, ST_EMPTY));
      directed_rows.push_back(row(OP_READ,   6'd0,  32'sd0, 1, 1, 32'sd0, 6'd0, ST_RANGE));
      directed_rows.push_back(row(OP_ERASE,  6'd0,  32'sd0, 1, 1, 32'sd0, 6'd0, ST_RANGE));
      directed_rows.push_back(row(OP_INSERT, 6'd1,  32'sd5, 1, 1, 32'sd0, 6'd0, ST_RANGE));
      directed_rows.push_back(row(OP_CLEAR,  6'd0,  32'sd0, 1, 1, 32'sd0, 6'd0, ST_OK));
      directed_rows.push_back(row(OP_APPEND, 6'd0,  32'h7FFFFFFF, 1, 1, 32'sd0, 6'd1, ST_OK));
      directed_rows.push_back(row(OP_INSERT, 6'd0,  32'h80000000, 1, 1, 32'sd0, 6'd2, ST_OK));
      directed_rows.push_back(row(OP_READ,   6'd0,  32'sd0, 1, 1, 32'h80000000, 6'd2, ST_OK));
      directed_rows.push_back(row(OP_READ,   6'd1,  32'sd0, 1, 1, 32'h7FFFFFFF, 6'd2, ST_OK));
      directed_rows.push_back(row(OP_READ,   6'd63, 32'sd0, 1, 1, 32'sd0, 6'd2, ST_RANGE));
      directed_rows.push_back(row(OP_INSERT, 6'd2,  -32'sd1, 1, 1, 32'sd0, 6'd3, ST_OK));
      directed_rows.push_back(row(OP_INSERT, 6'd1,  32'h13579BDF, 1, 0, '0, '0, ST_OK));
      directed_rows.push_back(row(OP_ERASE,  6'd1,  32'sd0, 1, 0, '0, '0, ST_OK));
      directed_rows.push_back(row(OP_ERASE,  6'd3,  32'sd0, 1, 1, 32'sd0, 6'd3, ST_RANGE));
      directed_rows.push_back(row(OP_READ,   6'd2,  32'sd0, 1, 1, -32'sd1, 6'd3, ST_OK));
      directed_rows.push_back(row(OP_UNUSED_LO, 6'd63, -32'sd1, 1, 1, 32'sd0, 6'd3, ST_OK));
      directed_rows.push_back(row(OP_UNUSED_HI, 6'd0,  32'sd9, 1, 1, 32'sd0, 6'd3, ST_OK));
      directed_rows.push_back(row(OP_APPEND, 6'd0,  32'h2468ACE0, 29, 0, '0, '0, ST_OK));
      directed_rows.push_back(row(OP_APPEND, 6'd0,  32'sd1, 1, 1, 32'sd0, 6'd32, ST_FULL));
      directed_rows.push_back(row(OP_INSERT, 6'd63, 32'sd1, 1, 1, 32'sd0, 6'd32, ST_FULL));
      directed_rows.push_back(row(OP_INSERT, 6'd32, 32'sd1, 1, 1, 32'sd0, 6'd32, ST_FULL));
      directed_rows.push_back(row(OP_READ,   6'd31, 32'sd0, 1, 0, '0, '0, ST_OK));
      directed_rows.push_back(row(OP_ERASE,  6'd31, 32'sd0, 1, 0, '0, '0, ST_OK));
      directed_rows.push_back(row(OP_INSERT, 6'd31, 32'h0F0F0F0F, 1, 0, '0, '0, ST_OK));
      directed_rows.push_back(row(OP_ERASE,  6'd0,  32'sd0, 1, 0, '0, '0, ST_OK));
      directed_rows.push_back(row(OP_DROP,   6'd0,  32'sd0, 1, 0, '0, '0, ST_OK));
      directed_rows.push_back(row(OP_CLEAR,  6'd17, 32'sd0, 1, 1, 32'sd0, 6'd0, ST_OK));
      directed_rows.push_back(row(OP_DROP,   6'd0,  32'sd0, 1, 1, 32'sd0, 6'd0, ST_EMPTY));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         for (k = 0; k < directed_rows[r].reps; k++)
            send_item(directed_rows[r].op, directed_rows[r].pos, directed_rows[r].val + k,
                      directed_rows[r].typed, directed_rows[r].want);
      end
      drain_results();

      grow       = 1'b1;
      gaps_on    = 1'b0;
      phase_left = $urandom_range(40, 160);
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (phase_left == 0) begin
            grow       = !grow;
            phase_left = $urandom_range(40, 160);
         end
         phase_left--;
         if (i % 150 == 0) gaps_on = 1'($urandom_range(1));

         roll = $urandom_range(99);
         if (roll < 2) op = (roll == 0) ? OP_UNUSED_LO : OP_UNUSED_HI;
         else if (roll < 3) op = OP_CLEAR;
         else if (roll < 40) op = grow ? OP_APPEND : OP_ERASE;
         else if (roll < 65) op = grow ? OP_INSERT : OP_DROP;
         else if (roll < 80) op = OP_READ;
         else if (roll < 90) op = grow ? OP_ERASE : OP_INSERT;
         else op = grow ? OP_DROP : OP_APPEND;

         if ($urandom_range(4) == 0) pos = 6'($urandom_range(63));
         else if (op == OP_INSERT) pos = 6'($urandom_range(shadow_count));
         else pos = (shadow_count == 0) ? 6'd0 : 6'($urandom_range(shadow_count - 1));

         case ($urandom_range(15))
            0:       val = 32'h80000000;
            1:       val = 32'h7FFFFFFF;
            2:       val = 32'sd0;
            3:       val = -32'sd1;
            default: val = $urandom;
         endcase

         send_item(op, pos, val, 1'b0, '0);

         // hold off once until the pipe is empty
         if (i == RANDOM_ITEMS / 2)
            drain_results();
         else if (gaps_on && i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(3) == 0)
            pause_sender($urandom_range(1, 6));
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (awaited_results.size() != 0)
         log_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

      $display("list store run: %0d items sent, %0d results checked, peak fill %0d of %0d",
               items_sent, results_seen, peak_count, LIST_DEPTH);
      $display("statuses seen: ok %0d, full %0d, empty %0d, range %0d; %0d mismatches",
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
               status_seen[ST_RANGE], error_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
